### rtl/fqlm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqlm_pkg
// Shared types and constants of the FIFO queue lock manager.
// ----------------------------------------------------------------------------
package fqlm_pkg;

  localparam int unsigned REQ_W    = 6;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ERR_W    = 2;

  // Command codes as they arrive on the input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE     = 2'd0,
    CMD_RELEASE     = 2'd1,
    CMD_RELEASE_SET = 2'd2,
    CMD_QUERY       = 2'd3
  } cmd_e;

  // Error codes reported with each result word.
  typedef enum logic [ERR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_DUP_ACQUIRE = 2'd1,
    ERR_NOT_HOLDER  = 2'd2
  } err_e;

  // A classified request as it travels from the front end to the back end.
  // A query is the case where none of the three flags is set.
  typedef struct packed {
    logic                acquire;
    logic                unlock;
    logic                set_status;
    logic [REQ_W-1:0]    req;
    logic [STATUS_W-1:0] status;
  } item_t;

  // One result word.
  typedef struct packed {
    logic                grant_valid;
    logic [REQ_W-1:0]    granted_agent;
    logic                queued;
    logic [STATUS_W-1:0] status_out;
    logic                alone;
    logic                lock_free;
    err_e                error_code;
  } result_t;

endpackage : fqlm_pkg
`default_nettype wire

### rtl/fqlm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqlm_front
// Accepts request words, decodes the command and holds them in a two-entry
// queue until the back end picks them up.
// ----------------------------------------------------------------------------
module fqlm_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [fqlm_pkg::CMD_W-1:0]    command_i,
  input  wire logic [fqlm_pkg::REQ_W-1:0]    requester_i,
  input  wire logic [fqlm_pkg::STATUS_W-1:0] status_in_i,
  output logic                               item_valid_o,
  output fqlm_pkg::item_t                    item_o,
  input  wire logic                          item_pop_i
);
  import fqlm_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  item_t             entry_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  item_t             decoded;
  logic              push;
  logic              full;

  always_comb begin
    decoded            = '0;
    decoded.req        = requester_i;
    decoded.status     = status_in_i;
    unique case (cmd_e'(command_i))
      CMD_ACQUIRE:     decoded.acquire = 1'b1;
      CMD_RELEASE:     decoded.unlock = 1'b1;
      CMD_RELEASE_SET: begin
        decoded.unlock     = 1'b1;
        decoded.set_status = 1'b1;
      end
      CMD_QUERY:       decoded.acquire = 1'b0;
      default:         decoded.acquire = 1'b0;
    endcase
  end

  assign full         = (count_q == CNT_W'(QDEPTH));
  assign in_stall_o   = full;
  assign push         = in_valid_i && !full;
  assign item_valid_o = (count_q != '0);
  assign item_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= decoded;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (item_pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !item_pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (item_pop_i && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule : fqlm_front
`default_nettype wire

### rtl/fqlm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqlm_back
// Carries out lock requests against the tail, holder, membership bits and
// the successor memory, and registers one result word per request.
// ----------------------------------------------------------------------------
module fqlm_back #(
  parameter int unsigned AGENT_COUNT = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          item_valid_i,
  input  wire fqlm_pkg::item_t               item_i,
  output logic                               item_pop_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fqlm_pkg::STATUS_W-1:0] cfg_status_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output fqlm_pkg::result_t                  result_o
);
  import fqlm_pkg::*;

  localparam int unsigned FULL_DEPTH = 2 ** REQ_W;
  localparam int unsigned DEPTH = (AGENT_COUNT < FULL_DEPTH) ? AGENT_COUNT : FULL_DEPTH;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_FETCH = 2'b01,
    ST_EXEC  = 2'b10
  } back_state_e;

  back_state_e         state_q, state_d;
  item_t               it_q;
  logic [REQ_W-1:0]    succ_rd_q;
  logic [REQ_W-1:0]    succ_mem [DEPTH];

  logic                tail_valid_q, tail_valid_d;
  logic [REQ_W-1:0]    tail_q, tail_d;
  logic [REQ_W-1:0]    holder_q, holder_d;
  logic [STATUS_W-1:0] cohort_q, cohort_d;
  logic [DEPTH-1:0]    inq_q, inq_d;
  logic                out_valid_q;
  result_t             res_q, res_d;

  logic                exec_fire;
  logic                req_ok;
  logic [IDX_W-1:0]    idx;
  logic                mem_we;

  assign item_pop_o  = (state_q == ST_FETCH) && item_valid_i;
  assign exec_fire   = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign req_ok      = (32'(it_q.req) < AGENT_COUNT);
  assign idx         = it_q.req[IDX_W-1:0];
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FETCH: if (item_pop_o) state_d = ST_EXEC;
      ST_EXEC:  if (exec_fire) state_d = ST_FETCH;
      default:  state_d = ST_FETCH;
    endcase
  end

  always_comb begin
    tail_valid_d = tail_valid_q;
    tail_d       = tail_q;
    holder_d     = holder_q;
    cohort_d     = cohort_q;
    inq_d        = inq_q;
    mem_we       = 1'b0;
    res_d        = '0;
    res_d.error_code = ERR_OK;

    if (it_q.acquire) begin
      if (!req_ok || inq_q[idx]) begin
        res_d.error_code = ERR_DUP_ACQUIRE;
      end else if (!tail_valid_q) begin
        tail_valid_d        = 1'b1;
        tail_d              = it_q.req;
        holder_d            = it_q.req;
        inq_d[idx]          = 1'b1;
        res_d.grant_valid   = 1'b1;
        res_d.granted_agent = it_q.req;
        res_d.status_out    = cohort_q;
      end else begin
        // Link behind the current tail.
        mem_we       = 1'b1;
        tail_d       = it_q.req;
        inq_d[idx]   = 1'b1;
        res_d.queued = 1'b1;
      end
    end else if (it_q.unlock) begin
      if (!req_ok || !tail_valid_q || (holder_q != it_q.req)) begin
        res_d.error_code = ERR_NOT_HOLDER;
      end else begin
        if (it_q.set_status) begin
          cohort_d = it_q.status;
        end
        inq_d[idx] = 1'b0;
        if (tail_q == it_q.req) begin
          tail_valid_d = 1'b0;
        end else begin
          // The holder is not the tail, so its successor entry was written.
          holder_d            = succ_rd_q;
          res_d.grant_valid   = 1'b1;
          res_d.granted_agent = succ_rd_q;
          res_d.status_out    = cohort_d;
        end
      end
    end else begin
      res_d.status_out = cohort_q;
    end

    res_d.alone     = req_ok && tail_valid_d && (tail_d == it_q.req);
    res_d.lock_free = !tail_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      it_q      <= item_i;
      succ_rd_q <= succ_mem[item_i.req[IDX_W-1:0]];
    end
    if (exec_fire && mem_we) begin
      succ_mem[tail_q[IDX_W-1:0]] <= it_q.req;
    end
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FETCH;
      tail_valid_q <= 1'b0;
      tail_q       <= '0;
      holder_q     <= '0;
      cohort_q     <= '0;
      inq_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        tail_valid_q <= tail_valid_d;
        tail_q       <= tail_d;
        holder_q     <= holder_d;
        inq_q        <= inq_d;
      end
      if (cfg_we_i) begin
        cohort_q <= cfg_status_i;
      end else if (exec_fire) begin
        cohort_q <= cohort_d;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule : fqlm_back
`default_nettype wire

### rtl/fifo_queue_lock_manager_core.sv
`default_nettype none
// A word accepted into the input queue is fetched into the back end, which
// reads the successor memory into a register and then commits the result word
// to the output register; it takes no new word until that commit is done.
// The two-entry input queue and the output register let either side stall.
// Reset (asynchronous, active low) frees the lock, clears all membership bits
// and sets the status byte to zero; the successor memory is not cleared.
// ----------------------------------------------------------------------------
// fifo_queue_lock_manager_core
// One mutual-exclusion lock granted to requesters in arrival order, with a
// cohort status byte that travels with each handoff.
// ----------------------------------------------------------------------------
module fifo_queue_lock_manager_core #(
  parameter int unsigned AGENT_COUNT = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration: the status byte register.
  input  wire logic                          initial_status_we_i,
  input  wire logic [fqlm_pkg::STATUS_W-1:0] initial_status_i,
  // Request words.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [fqlm_pkg::CMD_W-1:0]    command_i,
  input  wire logic [fqlm_pkg::REQ_W-1:0]    requester_i,
  input  wire logic [fqlm_pkg::STATUS_W-1:0] status_in_i,
  // Result words.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               grant_valid_o,
  output logic [fqlm_pkg::REQ_W-1:0]         granted_agent_o,
  output logic                               queued_o,
  output logic [fqlm_pkg::STATUS_W-1:0]      status_out_o,
  output logic                               alone_flag_o,
  output logic                               lock_free_o,
  output logic [fqlm_pkg::ERR_W-1:0]         error_code_o
);
  import fqlm_pkg::*;

  // The front end decodes each command and queues it; the back end owns all
  // lock state, so no request ever sees a half-updated queue.
  logic    item_valid;
  item_t   item;
  logic    item_pop;
  result_t result;

  fqlm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .requester_i  (requester_i),
    .status_in_i  (status_in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // A write to the status register loads the live status byte directly, so
  // the new value applies without a further reset.
  fqlm_back #(
    .AGENT_COUNT (AGENT_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cfg_we_i     (initial_status_we_i),
    .cfg_status_i (initial_status_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign grant_valid_o   = result.grant_valid;
  assign granted_agent_o = result.granted_agent;
  assign queued_o        = result.queued;
  assign status_out_o    = result.status_out;
  assign alone_flag_o    = result.alone;
  assign lock_free_o     = result.lock_free;
  assign error_code_o    = result.error_code;

endmodule : fifo_queue_lock_manager_core
`default_nettype wire

### rtl/fqlm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqlm_checker
// Port-level checks on the result words of the lock manager.
// ----------------------------------------------------------------------------
module fqlm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          grant_valid_o,
  input wire logic [fqlm_pkg::REQ_W-1:0]    granted_agent_o,
  input wire logic                          queued_o,
  input wire logic [fqlm_pkg::STATUS_W-1:0] status_out_o,
  input wire logic                          alone_flag_o,
  input wire logic                          lock_free_o,
  input wire logic [fqlm_pkg::ERR_W-1:0]    error_code_o
);
  import fqlm_pkg::*;

  // A stalled result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(granted_agent_o)
      && $stable(status_out_o) && $stable(error_code_o))
    else $error("stalled result word changed");

  // A grant and a queued report never come from the same request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(grant_valid_o && queued_o))
    else $error("grant and queued both set");

  // A rejected request changes nothing, so it neither grants nor queues.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_OK) |-> !grant_valid_o && !queued_o)
    else $error("error word carries a grant or queue report");

  // After a grant, a queued acquire or an alone report someone holds the lock.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (grant_valid_o || queued_o || alone_flag_o) |-> !lock_free_o)
    else $error("lock reported free while held");

  // Only the three defined error codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_code_o == ERR_OK) || (error_code_o == ERR_DUP_ACQUIRE)
      || (error_code_o == ERR_NOT_HOLDER))
    else $error("undefined error code");

endmodule : fqlm_checker

bind fifo_queue_lock_manager_core fqlm_checker u_fqlm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .grant_valid_o   (grant_valid_o),
  .granted_agent_o (granted_agent_o),
  .queued_o        (queued_o),
  .status_out_o    (status_out_o),
  .alone_flag_o    (alone_flag_o),
  .lock_free_o     (lock_free_o),
  .error_code_o    (error_code_o)
);
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO queue lock manager core. It plans a stream
// of lock requests, drives them with random gaps on both handshakes, predicts
// each result word from its own model of the lock queue, and compares every
// result word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import fqlm_pkg::*;

  localparam int unsigned AGENTS         = 64;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_WORDS    = 205;
  localparam int unsigned PRESSURE_PHASE = 3;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned TIMEOUT_CYCLES = 400000;

  // One planned request word, as the driver puts it on the input port.
  typedef struct {
    cmd_e                cmd;
    logic [REQ_W-1:0]    agent;
    logic [STATUS_W-1:0] status;
  } lock_request_t;

  // Every input of the core starts at a known value.
  logic                clk_i               = 1'b0;
  logic                rst_ni              = 1'b0;
  logic                initial_status_we_i = 1'b0;
  logic [STATUS_W-1:0] initial_status_i    = '0;
  logic                in_valid_i          = 1'b0;
  logic [CMD_W-1:0]    command_i           = CMD_ACQUIRE;
  logic [REQ_W-1:0]    requester_i         = '0;
  logic [STATUS_W-1:0] status_in_i         = '0;
  logic                out_stall_i         = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic                grant_valid_o;
  logic [REQ_W-1:0]    granted_agent_o;
  logic                queued_o;
  logic [STATUS_W-1:0] status_out_o;
  logic                alone_flag_o;
  logic                lock_free_o;
  logic [ERR_W-1:0]    error_code_o;

  fifo_queue_lock_manager_core #(
    .AGENT_COUNT(AGENTS)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .initial_status_we_i(initial_status_we_i),
    .initial_status_i   (initial_status_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .requester_i        (requester_i),
    .status_in_i        (status_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .grant_valid_o      (grant_valid_o),
    .granted_agent_o    (granted_agent_o),
    .queued_o           (queued_o),
    .status_out_o       (status_out_o),
    .alone_flag_o       (alone_flag_o),
    .lock_free_o        (lock_free_o),
    .error_code_o       (error_code_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Lock queue model. These variables mirror the core's state and, once set up at
  // time zero, are only touched from the sampling block at the rising edge.
  // --------------------------------------------------------------------------
  logic                line_busy;
  logic [REQ_W-1:0]    line_tail;
  logic [REQ_W-1:0]    lock_holder;
  logic [REQ_W-1:0]    next_in_line [AGENTS];
  logic [AGENTS-1:0]   line_member;
  logic [STATUS_W-1:0] lock_status;

  initial begin
    line_busy   = 1'b0;
    line_tail   = '0;
    lock_holder = '0;
    line_member = '0;
    lock_status = '0;
    foreach (next_in_line[k]) next_in_line[k] = '0;
  end

  // Applies one request word to the model and returns the result word that the
  // core must answer with.
  function automatic result_t resolve_lock_request(cmd_e cmd, logic [REQ_W-1:0] who,
                                                   logic [STATUS_W-1:0] new_status);
    result_t r;
    r            = '0;
    r.error_code = ERR_OK;
    case (cmd)
      CMD_ACQUIRE: begin
        if (line_member[who]) begin
          // The agent already holds the lock or waits for it.
          r.error_code = ERR_DUP_ACQUIRE;
        end else if (!line_busy) begin
          line_busy        = 1'b1;
          line_tail        = who;
          lock_holder      = who;
          line_member[who] = 1'b1;
          r.grant_valid    = 1'b1;
          r.granted_agent  = who;
          r.status_out     = lock_status;
        end else begin
          // Link behind the old tail and wait.
          next_in_line[line_tail] = who;
          line_tail               = who;
          line_member[who]        = 1'b1;
          r.queued                = 1'b1;
        end
      end
      CMD_RELEASE, CMD_RELEASE_SET: begin
        if (!line_busy || lock_holder != who) begin
          r.error_code = ERR_NOT_HOLDER;
        end else begin
          if (cmd == CMD_RELEASE_SET) lock_status = new_status;
          if (line_tail == who) begin
            line_busy = 1'b0;
          end else begin
            // Hand the lock to the recorded successor in the same step.
            lock_holder     = next_in_line[who];
            r.grant_valid   = 1'b1;
            r.granted_agent = next_in_line[who];
            r.status_out    = lock_status;
          end
          line_member[who] = 1'b0;
        end
      end
      default: begin
        r.status_out = lock_status;
      end
    endcase
    r.alone     = line_busy && (line_tail == who);
    r.lock_free = !line_busy;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared bookkeeping between the planner, the driver and the sampler.
  // --------------------------------------------------------------------------
  lock_request_t request_backlog[$];
  result_t       pending_answers[$];
  int unsigned   planned_total  = 0;
  int unsigned   accepted_total = 0;
  int unsigned   answer_index   = 0;
  int unsigned   mismatches     = 0;

  // Handshake outcomes of the last rising edge, used by the falling-edge logic.
  logic          in_took  = 1'b0;
  logic          out_took = 1'b0;

  // Idling controls. The planner sets quiet flags and pressure_go at a rising edge.
  logic          sender_quiet   = 1'b0;
  logic          receiver_quiet = 1'b0;
  logic          pressure_go    = 1'b0;
  logic          hold_on        = 1'b0;
  int unsigned   send_wait      = 0;
  int unsigned   recv_wait      = 0;

  // The planner keeps a shadow of the arrival order so that most releases come
  // from the real holder and reach deep into the handoff logic.
  logic [REQ_W-1:0]  plan_line[$];
  logic [AGENTS-1:0] plan_member = '0;

  task automatic plan_request(cmd_e cmd, logic [REQ_W-1:0] who, logic [STATUS_W-1:0] st);
    lock_request_t req;
    req.cmd    = cmd;
    req.agent  = who;
    req.status = st;
    case (cmd)
      CMD_ACQUIRE: begin
        if (!plan_member[who]) begin
          plan_member[who] = 1'b1;
          plan_line.push_back(who);
        end
      end
      CMD_RELEASE, CMD_RELEASE_SET: begin
        if (plan_line.size() != 0 && plan_line[0] == who) begin
          plan_member[who] = 1'b0;
          void'(plan_line.pop_front());
        end
      end
      default: begin
      end
    endcase
    request_backlog.push_back(req);
    planned_total++;
  endtask

  // Random traffic around a small pool of agents or all of them, mostly well-formed
  // acquire and holder-release sequences, with some misdirected releases and noise.
  task automatic plan_random_words(int unsigned count);
    logic [REQ_W-1:0]    pool [8];
    int unsigned         pool_size;
    int unsigned         roll;
    logic [REQ_W-1:0]    who;
    logic [STATUS_W-1:0] st;
    case ($urandom_range(0, 4))
      0:       pool_size = 2;
      1:       pool_size = 3;
      2:       pool_size = 5;
      3:       pool_size = 8;
      default: pool_size = AGENTS;
    endcase
    foreach (pool[k]) pool[k] = REQ_W'($urandom_range(0, AGENTS - 1));
    repeat (count) begin
      roll = $urandom_range(0, 99);
      who  = (pool_size == AGENTS) ? REQ_W'($urandom_range(0, AGENTS - 1))
                                   : pool[$urandom_range(0, pool_size - 1)];
      st   = STATUS_W'($urandom_range(0, 255));
      if (roll < 38) begin
        plan_request(CMD_ACQUIRE, who, st);
      end else if (roll < 76 && plan_line.size() != 0) begin
        plan_request($urandom_range(0, 1) ? CMD_RELEASE_SET : CMD_RELEASE, plan_line[0], st);
      end else if (roll < 84) begin
        plan_request($urandom_range(0, 1) ? CMD_RELEASE_SET : CMD_RELEASE, who, st);
      end else if (roll < 92) begin
        if ($urandom_range(0, 1) && plan_line.size() != 0) begin
          who = plan_line[plan_line.size() - 1];
        end
        plan_request(CMD_QUERY, who, st);
      end else begin
        plan_request(cmd_e'($urandom_range(0, 3)), REQ_W'($urandom_range(0, AGENTS - 1)),
                     st);
      end
    end
  endtask

  // Waits until every planned word has been taken and answered, then lets the
  // pipeline settle. Counters are updated at the rising edge and read here at
  // the falling edge.
  task automatic wait_until_drained();
    while (accepted_total != planned_total || pending_answers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes the status register while the core is idle.
  task automatic write_status_register(logic [STATUS_W-1:0] value);
    @(negedge clk_i);
    initial_status_we_i <= 1'b1;
    initial_status_i    <= value;
    @(negedge clk_i);
    initial_status_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Request driver. A word stays on the port until the edge that takes it;
  // after that the sender waits the gap it drew for that word.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_requests
    lock_request_t nxt;
    if (rst_ni && !(in_valid_i && !in_took)) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid_i <= 1'b0;
      end else if (request_backlog.size() != 0) begin
        nxt         = request_backlog.pop_front();
        in_valid_i  <= 1'b1;
        command_i   <= nxt.cmd;
        requester_i <= nxt.agent;
        status_in_i <= nxt.status;
        send_wait   = sender_quiet ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver. After each word taken it draws a stall length; a long
  // hold-off from the pressure process overrides it.
  always @(negedge clk_i) begin : drive_result_stall
    if (rst_ni) begin
      if (out_took) recv_wait = receiver_quiet ? 0 : $urandom_range(0, 11);
      if (hold_on) begin
        out_stall_i <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here, while the sender keeps offering
  // words so that the core fills up and stalls its input.
  initial begin : pressure_hold
    wait (pressure_go);
    @(negedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_on <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sampler. Register writes and accepted request words update the model;
  // every result word taken is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_ports
    result_t want;
    in_took  <= rst_ni && in_valid_i && !in_stall_o;
    out_took <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (initial_status_we_i) lock_status = initial_status_i;
      if (in_valid_i && !in_stall_o) begin
        pending_answers.push_back(resolve_lock_request(cmd_e'(command_i), requester_i,
                                                       status_in_i));
        accepted_total++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          if (mismatches < 10) begin
            $display("result word %0d arrived with no request outstanding", answer_index);
          end
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          if (grant_valid_o   !== want.grant_valid   ||
              granted_agent_o !== want.granted_agent ||
              queued_o        !== want.queued        ||
              status_out_o    !== want.status_out    ||
              alone_flag_o    !== want.alone         ||
              lock_free_o     !== want.lock_free     ||
              error_code_o    !== want.error_code) begin
            if (mismatches < 10) begin
              $display("result word %0d: want grant=%0b agent=%0d queued=%0b status=%02h",
                       answer_index, want.grant_valid, want.granted_agent, want.queued,
                       want.status_out, " alone=%0b free=%0b err=%0d",
                       want.alone, want.lock_free, want.error_code);
              $display("result word %0d: got  grant=%0b agent=%0d queued=%0b status=%02h",
                       answer_index, grant_valid_o, granted_agent_o, queued_o,
                       status_out_o, " alone=%0b free=%0b err=%0d",
                       alone_flag_o, lock_free_o, error_code_o);
            end
            mismatches++;
          end
        end
        answer_index++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Planner: reset, then phases separated by idle register writes.
  // --------------------------------------------------------------------------
  initial begin : run_phases
    logic [STATUS_W-1:0] status_setting [PHASES];
    status_setting[0] = 8'hFF;
    status_setting[1] = 8'h00;
    status_setting[2] = STATUS_W'($urandom_range(0, 255));
    status_setting[3] = 8'h80;
    status_setting[4] = STATUS_W'($urandom_range(0, 255));
    status_setting[5] = 8'h7F;
    status_setting[6] = STATUS_W'($urandom_range(0, 255));
    status_setting[7] = 8'h01;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      write_status_register(status_setting[phase]);
      @(posedge clk_i);
      if (phase == 1) begin
        // A stretch with no idling on either side.
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b1;
      end else if (phase == PRESSURE_PHASE) begin
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b0;
        pressure_go    = 1'b1;
      end else begin
        sender_quiet   = ($urandom_range(0, 3) == 0);
        receiver_quiet = ($urandom_range(0, 3) == 0);
      end
      if (phase == 0) begin
        // Requests against a free lock: query, releases by a non-holder.
        plan_request(CMD_QUERY,       6'd0,  8'hAA);
        plan_request(CMD_RELEASE,     6'd0,  8'h55);
        plan_request(CMD_RELEASE_SET, 6'd63, 8'hFF);
        // Immediate grant, then duplicate acquires by the holder and a waiter.
        plan_request(CMD_ACQUIRE,     6'd0,  8'h00);
        plan_request(CMD_ACQUIRE,     6'd0,  8'hFF);
        plan_request(CMD_ACQUIRE,     6'd63, 8'h55);
        plan_request(CMD_ACQUIRE,     6'd63, 8'hAA);
        plan_request(CMD_QUERY,       6'd63, 8'h00);
        plan_request(CMD_QUERY,       6'd0,  8'hFF);
        // A waiter tries to release; then the holder hands off with a new status.
        plan_request(CMD_RELEASE,     6'd63, 8'h00);
        plan_request(CMD_RELEASE_SET, 6'd0,  8'hFF);
        plan_request(CMD_ACQUIRE,     6'd21, 8'h00);
        plan_request(CMD_ACQUIRE,     6'd42, 8'h00);
        plan_request(CMD_RELEASE,     6'd63, 8'h33);
        plan_request(CMD_RELEASE_SET, 6'd21, 8'h00);
        // The tail releases and sets a new status; the lock goes free and keeps it.
        plan_request(CMD_RELEASE_SET, 6'd42, 8'hA5);
        plan_request(CMD_QUERY,       6'd42, 8'h00);
        plan_request(CMD_ACQUIRE,     6'd42, 8'h5A);
        plan_request(CMD_RELEASE,     6'd42, 8'hC3);
        plan_request(CMD_RELEASE_SET, 6'd42, 8'h5A);
      end else begin
        plan_random_words(PHASE_WORDS);
      end
      wait_until_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_answers.size() != 0) begin
      $display("%0d result words never arrived", pending_answers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("fifo_queue_lock_manager_core: match");
    end else begin
      $display("fifo_queue_lock_manager_core: mismatch");
    end
    $finish;
  end

  // Overall limit, many times the slowest correct run.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * 10);
    $display("fifo_queue_lock_manager_core: mismatch");
    $finish;
  end

endmodule : tb_top
`default_nettype wire

### files.f
rtl/fqlm_pkg.sv
rtl/fqlm_front.sv
rtl/fqlm_back.sv
rtl/fifo_queue_lock_manager_core.sv
rtl/fqlm_checker.sv
verif/tb_top.sv
